/* rtl/core/prf_pkg.sv */
// Shared types and codes for the packet ring FIFO.
// Used by prf_front, prf_back and packet_ring_fifo; depends on nothing.
`default_nettype none

package prf_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_SNOOP = 2'd2,
    OP_DROP  = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic [7:0] limit;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/prf_front.sv */
// Front end: accepts command transactions, classifies them and holds them in a
// two-entry command queue for the back end. Depends on prf_pkg.
`default_nettype none

module prf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic [1:0]    kind_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          byte_valid_i,
  input  wire logic          last_i,
  input  wire logic [7:0]    read_limit_i,
  output logic               cmd_valid_o,
  output prf_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i
);
  import prf_pkg::*;

  cmd_t       entry_q [2];
  cmd_t       cls_cmd;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Only the fields that the operation uses are carried on.
  always_comb begin
    cls_cmd            = '0;
    cls_cmd.op         = op_e'(kind_i);
    unique case (cls_cmd.op)
      OP_PUSH: begin
        cls_cmd.data       = data_byte_i;
        cls_cmd.byte_valid = byte_valid_i;
        cls_cmd.last       = last_i;
      end
      OP_POP, OP_SNOOP: cls_cmd.limit = read_limit_i;
      OP_DROP: ;
      default: ;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/prf_back.sv */
// Back end: executes queued commands against the packet and length memories,
// keeps the ring pointers and drives the result register. Depends on prf_pkg.
`default_nettype none

module prf_back #(
  parameter int SLOTS     = 8,
  parameter int PKT_BYTES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire prf_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  input  wire logic          cfg_write_i,
  input  wire logic [3:0]    cfg_slots_i,
  output logic               res_valid_o,
  output logic [1:0]         status_o,
  output logic [7:0]         out_byte_o,
  output logic [4:0]         packet_length_o,
  output logic [3:0]         queue_depth_o,
  output logic               end_of_run_o
);
  import prf_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = $clog2(PKT_BYTES + 1);
  localparam int AW = $clog2(SLOTS * PKT_BYTES);
  localparam int UW = (CW > 4) ? CW : 4;
  localparam int RESET_SLOTS = (SLOTS < 8) ? SLOTS : 8;

  typedef enum logic [1:0] {S_IDLE, S_LEN, S_RUN} state_e;

  logic [7:0]    pkt_mem [SLOTS * PKT_BYTES];
  logic [LW-1:0] len_mem [SLOTS];

  state_e        state_q, state_d;
  logic [3:0]    slots_q, slots_d;
  logic [SW-1:0] wr_slot_q, wr_slot_d, rd_slot_q, rd_slot_d;
  logic [AW-1:0] wr_base_q, wr_base_d, rd_base_q, rd_base_d;
  logic [AW-1:0] run_base_q, run_base_d;
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] bw_q, bw_d;
  logic          rej_q, rej_d;
  logic          pop_q, pop_d;
  logic [7:0]    limit_q, limit_d;
  logic [LW-1:0] n_q, n_d, idx_q, idx_d;
  logic          res_valid_q, res_valid_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [4:0]    res_len_q, res_len_d;
  logic [3:0]    res_depth_q, res_depth_d;
  logic          res_end_q, res_end_d;
  logic          res_sel_q, res_sel_d;

  logic          pkt_we, len_we;
  logic [AW-1:0] pkt_waddr, pkt_raddr;
  logic [LW-1:0] len_wdata;
  logic [7:0]    rdata_q;
  logic [LW-1:0] len_rd_q;

  logic [UW-1:0] slots_ext;
  logic [CW-1:0] used;
  logic          wr_wrap, rd_wrap, open, reject, fits, run_end;
  logic [LW-1:0] bw_new;
  logic [7:0]    lim_len, run_len;

  // A register value of zero counts as one slot, and any value above SLOTS as SLOTS.
  always_comb begin
    slots_ext = UW'(slots_q);
    if (slots_ext == '0) begin
      used = CW'(1);
    end else if (slots_ext > UW'(SLOTS)) begin
      used = CW'(SLOTS);
    end else begin
      used = CW'(slots_ext);
    end
  end

  assign wr_wrap = (CW'(wr_slot_q) + CW'(1)) >= used;
  assign rd_wrap = (CW'(rd_slot_q) + CW'(1)) >= used;
  assign open    = rej_q || (bw_q != '0);
  assign reject  = rej_q || (!open && (count_q >= used));
  assign fits    = cmd_i.byte_valid && (bw_q < LW'(PKT_BYTES));
  assign bw_new  = fits ? bw_q + LW'(1) : bw_q;
  assign run_end = (idx_q + LW'(1)) == n_q;

  always_comb begin
    lim_len = (limit_q < 8'(len_rd_q)) ? limit_q : 8'(len_rd_q);
    run_len = (lim_len > 8'(PKT_BYTES)) ? 8'(PKT_BYTES) : lim_len;
  end

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    slots_d      = slots_q;
    wr_slot_d    = wr_slot_q;
    rd_slot_d    = rd_slot_q;
    wr_base_d    = wr_base_q;
    rd_base_d    = rd_base_q;
    run_base_d   = run_base_q;
    count_d      = count_q;
    bw_d         = bw_q;
    rej_d        = rej_q;
    pop_d        = pop_q;
    limit_d      = limit_q;
    n_d          = n_q;
    idx_d        = idx_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_len_d    = '0;
    res_end_d    = 1'b1;
    res_sel_d    = 1'b0;
    pkt_we       = 1'b0;
    pkt_waddr    = wr_base_q + AW'(bw_q);
    len_we       = 1'b0;
    len_wdata    = bw_new;
    pkt_raddr    = run_base_q + AW'(idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          res_valid_d = 1'b1;
          if (cmd_i.op == OP_PUSH) begin
            if (reject) begin
              rej_d        = !cmd_i.last;
              res_status_d = ST_FULL;
            end else begin
              pkt_we = fits;
              bw_d   = bw_new;
              if (cmd_i.last) begin
                len_we    = 1'b1;
                wr_slot_d = wr_wrap ? '0 : wr_slot_q + SW'(1);
                wr_base_d = wr_wrap ? '0 : wr_base_q + AW'(PKT_BYTES);
                count_d   = count_q + CW'(1);
                bw_d      = '0;
              end
            end
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
          end else if (cmd_i.op == OP_DROP) begin
            rd_slot_d = rd_wrap ? '0 : rd_slot_q + SW'(1);
            rd_base_d = rd_wrap ? '0 : rd_base_q + AW'(PKT_BYTES);
            count_d   = count_q - CW'(1);
          end else begin
            // Pop or snoop: the stored length is read on this edge.
            res_valid_d = 1'b0;
            pop_d       = (cmd_i.op == OP_POP);
            limit_d     = cmd_i.limit;
            state_d     = S_LEN;
          end
        end
      end
      S_LEN: begin
        run_base_d = rd_base_q;
        if (pop_q) begin
          rd_slot_d = rd_wrap ? '0 : rd_slot_q + SW'(1);
          rd_base_d = rd_wrap ? '0 : rd_base_q + AW'(PKT_BYTES);
          count_d   = count_q - CW'(1);
        end
        if (run_len == 8'd0) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          n_d     = LW'(run_len);
          idx_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        res_valid_d = 1'b1;
        res_sel_d   = 1'b1;
        res_len_d   = 5'(n_q);
        res_end_d   = run_end;
        idx_d       = idx_q + LW'(1);
        if (run_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A register write empties the queue; write it only while idle, as nothing checks.
    if (cfg_write_i) begin
      slots_d   = cfg_slots_i;
      wr_slot_d = '0;
      rd_slot_d = '0;
      wr_base_d = '0;
      rd_base_d = '0;
      count_d   = '0;
      bw_d      = '0;
      rej_d     = 1'b0;
    end

    res_depth_d = 4'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slots_q      <= 4'(RESET_SLOTS);
      wr_slot_q    <= '0;
      rd_slot_q    <= '0;
      wr_base_q    <= '0;
      rd_base_q    <= '0;
      count_q      <= '0;
      bw_q         <= '0;
      rej_q        <= 1'b0;
      res_valid_q  <= 1'b0;
      run_base_q   <= '0;
      pop_q        <= 1'b0;
      limit_q      <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      res_status_q <= ST_OK;
      res_len_q    <= '0;
      res_depth_q  <= '0;
      res_end_q    <= 1'b0;
      res_sel_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      slots_q      <= slots_d;
      wr_slot_q    <= wr_slot_d;
      rd_slot_q    <= rd_slot_d;
      wr_base_q    <= wr_base_d;
      rd_base_q    <= rd_base_d;
      count_q      <= count_d;
      bw_q         <= bw_d;
      rej_q        <= rej_d;
      res_valid_q  <= res_valid_d;
      run_base_q   <= run_base_d;
      pop_q        <= pop_d;
      limit_q      <= limit_d;
      n_q          <= n_d;
      idx_q        <= idx_d;
      res_status_q <= res_status_d;
      res_len_q    <= res_len_d;
      res_depth_q  <= res_depth_d;
      res_end_q    <= res_end_d;
      res_sel_q    <= res_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_we) begin
      pkt_mem[pkt_waddr] <= cmd_i.data;
    end
    rdata_q <= pkt_mem[pkt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[wr_slot_q] <= len_wdata;
    end
    len_rd_q <= len_mem[rd_slot_q];
  end

  assign res_valid_o     = res_valid_q;
  assign status_o        = res_status_q;
  assign out_byte_o      = res_sel_q ? rdata_q : 8'd0;
  assign packet_length_o = res_len_q;
  assign queue_depth_o   = res_depth_q;
  assign end_of_run_o    = res_end_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("packet count above the number of slots");

  a_reject_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q |-> (bw_q == '0))
    else $error("bytes held while a packet is being rejected");

  a_run_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |=> (res_valid_q && res_sel_q))
    else $error("run cycle without a byte result");

  a_byte_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_sel_q) |-> (res_status_q == ST_OK && res_len_q != 5'd0 ||
                                    res_status_q == ST_OK && LW > 5))
    else $error("byte result with a bad status or length");

endmodule

`default_nettype wire

/* rtl/core/packet_ring_fifo.sv */
// Top level of the packet ring FIFO: command front end, command queue and
// execution back end. Depends on prf_pkg, prf_front and prf_back.
//
//   channel   handshake                 payload
//   command   start_i / busy_o          kind_i, data_byte_i, byte_valid_i, last_i,
//                                       read_limit_i
//   result    out_strobe_o (one cycle)  status_o, out_byte_o, packet_length_o,
//                                       queue_depth_o, end_of_run_o
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (slots in use)
//
// Push, drop and empty-queue commands give their result through the result
// register and can follow one another every cycle while the back end is idle.
// Pop and snoop go through the back end's length memory read, its length state,
// then one packet memory read per byte, each through the result register.
// busy_o rises while the two-entry command queue is full. The result side
// cannot stall. Reset clears pointers, counts and the slot register to
// min(SLOTS, 8); the packet and length memories need no clearing.
`default_nettype none

module packet_ring_fifo #(
  parameter int SLOTS     = 8,
  parameter int PKT_BYTES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_valid_i,
  input  wire logic       last_i,
  input  wire logic [7:0] read_limit_i,
  output logic            out_strobe_o,
  output logic [1:0]      status_o,
  output logic [7:0]      out_byte_o,
  output logic [4:0]      packet_length_o,
  output logic [3:0]      queue_depth_o,
  output logic            end_of_run_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [3:0] cfg_data_i
);
  import prf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  assign cfg_ready_o = 1'b1;

  prf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .read_limit_i (read_limit_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  prf_back #(
    .SLOTS     (SLOTS),
    .PKT_BYTES (PKT_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_ready_o     (cmd_ready),
    .cfg_write_i     (cfg_valid_i && cfg_ready_o),
    .cfg_slots_i     (cfg_data_i),
    .res_valid_o     (out_strobe_o),
    .status_o        (status_o),
    .out_byte_o      (out_byte_o),
    .packet_length_o (packet_length_o),
    .queue_depth_o   (queue_depth_o),
    .end_of_run_o    (end_of_run_o)
  );

endmodule

`default_nettype wire

/* verif/tb_packet_ring_fifo.sv */
// Self-checking testbench for packet_ring_fifo: directed table, then random packet traffic.
// Results are checked against a ring-queue predictor. Depends on prf_pkg and the RTL only.
module tb_packet_ring_fifo;
  import prf_pkg::*;

  localparam int SLOTS     = 8;
  localparam int PKT_BYTES = 16;
  localparam int MEM_AW    = $clog2(SLOTS * PKT_BYTES);
  localparam int SLOT_W    = $clog2(SLOTS);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [4:0] length;
    logic [3:0] depth;
    logic       eor;
  } beat_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       vld;
    logic       lst;
    logic [7:0] limit;
    logic [4:0] reps;
    logic       typed;
    logic [1:0] st;
    logic [3:0] depth;
  } dir_row_t;

  // Run with one slot in use, so that the queue fills after a single packet.
  localparam dir_row_t DIRECTED [12] = '{
    '{OP_POP,   8'h00, 1'b0, 1'b0, 8'hFF, 5'd1,  1'b1, ST_EMPTY, 4'd0},
    '{OP_DROP,  8'h00, 1'b0, 1'b0, 8'h00, 5'd1,  1'b1, ST_EMPTY, 4'd0},
    '{OP_PUSH,  8'h00, 1'b0, 1'b1, 8'h00, 5'd1,  1'b1, ST_OK,    4'd1},
    '{OP_PUSH,  8'hFF, 1'b1, 1'b0, 8'h00, 5'd1,  1'b1, ST_FULL,  4'd1},
    '{OP_PUSH,  8'h00, 1'b1, 1'b1, 8'h00, 5'd1,  1'b1, ST_FULL,  4'd1},
    '{OP_SNOOP, 8'h00, 1'b0, 1'b0, 8'hFF, 5'd1,  1'b1, ST_OK,    4'd1},
    '{OP_POP,   8'h00, 1'b0, 1'b0, 8'h00, 5'd1,  1'b1, ST_OK,    4'd0},
    '{OP_PUSH,  8'h3C, 1'b1, 1'b1, 8'h00, 5'd17, 1'b0, ST_OK,    4'd0},
    '{OP_SNOOP, 8'h00, 1'b0, 1'b0, 8'h03, 5'd1,  1'b0, ST_OK,    4'd0},
    '{OP_POP,   8'h00, 1'b0, 1'b0, 8'hFF, 5'd1,  1'b0, ST_OK,    4'd0},
    '{OP_PUSH,  8'hA5, 1'b1, 1'b1, 8'h00, 5'd1,  1'b1, ST_OK,    4'd1},
    '{OP_DROP,  8'h00, 1'b0, 1'b0, 8'h00, 5'd1,  1'b1, ST_OK,    4'd0}
  };

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start_i      = 1'b0;
  logic [1:0] kind_i       = OP_PUSH;
  logic [7:0] data_byte_i  = 8'h00;
  logic       byte_valid_i = 1'b0;
  logic       last_i       = 1'b0;
  logic [7:0] read_limit_i = 8'h00;
  logic       cfg_valid_i  = 1'b0;
  logic [3:0] cfg_data_i   = 4'd0;
  logic       busy_o;
  logic       out_strobe_o;
  logic [1:0] status_o;
  logic [7:0] out_byte_o;
  logic [4:0] packet_length_o;
  logic [3:0] queue_depth_o;
  logic       end_of_run_o;
  logic       cfg_ready_o;

  packet_ring_fifo #(
    .SLOTS    (SLOTS),
    .PKT_BYTES(PKT_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .byte_valid_i   (byte_valid_i),
    .last_i         (last_i),
    .read_limit_i   (read_limit_i),
    .out_strobe_o   (out_strobe_o),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .packet_length_o(packet_length_o),
    .queue_depth_o  (queue_depth_o),
    .end_of_run_o   (end_of_run_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Predicted state of the ring.
  logic [7:0]  ring_bytes [SLOTS*PKT_BYTES];
  logic [4:0]  ring_lengths [SLOTS];
  int unsigned wr_slot, rd_slot, held_packets, open_bytes;
  bit          rejecting;
  logic [3:0]  slots_reg;
  beat_t       pending_beats [$];
  int          mismatches;
  bit          burst;

  function automatic int unsigned ring_size();
    if (slots_reg < 1) return 1;
    if (slots_reg > SLOTS) return SLOTS;
    return 32'(slots_reg);
  endfunction

  function automatic int unsigned step_slot(input int unsigned s);
    return (s + 1 >= ring_size()) ? 0 : s + 1;
  endfunction

  function automatic beat_t make_beat(input logic [1:0] st, input logic [7:0] b,
                                      input logic [4:0] len, input logic eor);
    beat_t r;
    r.status = st;
    r.data   = b;
    r.length = len;
    r.depth  = held_packets[3:0];
    r.eor    = eor;
    return r;
  endfunction

  // Applies one command to the predicted ring; queues the beats it yields if keep is set.
  task automatic apply_ring_op(input op_e op, input logic [7:0] data, input logic vld,
                               input logic lst, input logic [7:0] limit, input bit keep);
    beat_t       run [$];
    int unsigned slot, n, stored, lim;
    if (op == OP_PUSH) begin
      if (!rejecting && open_bytes == 0 && held_packets >= ring_size()) rejecting = 1'b1;
      if (rejecting) begin
        if (lst) rejecting = 1'b0;
        run.push_back(make_beat(ST_FULL, 8'h00, 5'd0, 1'b1));
      end else begin
        if (vld && open_bytes < PKT_BYTES) begin
          ring_bytes[MEM_AW'(wr_slot*PKT_BYTES + open_bytes)] = data;
          open_bytes++;
        end
        if (lst) begin
          ring_lengths[SLOT_W'(wr_slot)] = open_bytes[4:0];
          wr_slot = step_slot(wr_slot);
          held_packets++;
          open_bytes = 0;
        end
        run.push_back(make_beat(ST_OK, 8'h00, 5'd0, 1'b1));
      end
    end else if (held_packets == 0) begin
      run.push_back(make_beat(ST_EMPTY, 8'h00, 5'd0, 1'b1));
    end else if (op == OP_DROP) begin
      rd_slot = step_slot(rd_slot);
      held_packets--;
      run.push_back(make_beat(ST_OK, 8'h00, 5'd0, 1'b1));
    end else begin
      slot   = rd_slot;
      stored = 32'(ring_lengths[SLOT_W'(slot)]);
      lim    = 32'(limit);
      n = (lim < stored) ? lim : stored;
      if (n > PKT_BYTES) n = PKT_BYTES;
      if (op == OP_POP) begin
        rd_slot = step_slot(rd_slot);
        held_packets--;
      end
      if (n == 0) run.push_back(make_beat(ST_OK, 8'h00, 5'd0, 1'b1));
      for (int i = 0; i < n; i++)
        run.push_back(make_beat(ST_OK, ring_bytes[MEM_AW'(slot*PKT_BYTES + i)], n[4:0],
                                i + 1 == n));
    end
    if (keep) pending_beats = {pending_beats, run};
  endtask

  // Drives one command and waits for its transaction. Called at a rising edge.
  task automatic send_cmd(input op_e op, input logic [7:0] data, input logic vld,
                          input logic lst, input logic [7:0] limit, input bit typed,
                          input logic [1:0] st, input logic [3:0] depth);
    int unsigned gap;
    beat_t       want;
    if ($urandom_range(7) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= op;
    data_byte_i  <= data;
    byte_valid_i <= vld;
    last_i       <= lst;
    read_limit_i <= limit;
    do @(posedge clk_i); while (busy_o);
    apply_ring_op(op, data, vld, lst, limit, !typed);
    if (typed) begin
      want.status = st;
      want.data   = 8'h00;
      want.length = 5'd0;
      want.depth  = depth;
      want.eor    = 1'b1;
      pending_beats.push_back(want);
    end
  endtask

  // Writing the slot register empties the queue, so it is only done once all runs are out.
  task automatic write_slots(input logic [3:0] value);
    start_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    slots_reg    = value;
    wr_slot      = 0;
    rd_slot      = 0;
    held_packets = 0;
    open_bytes   = 0;
    rejecting    = 1'b0;
  endtask

  task automatic random_phase(input logic [3:0] slots, input int quota);
    int   sent, plen, push_pct;
    logic vld;
    write_slots(slots);
    push_pct = $urandom_range(35, 75);
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < push_pct) begin
        plen = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 16);
        if (plen == 0) begin
          send_cmd(OP_PUSH, 8'($urandom_range(255)), 1'b0, 1'b1, 8'($urandom_range(255)),
                   1'b0, ST_OK, 4'd0);
          sent++;
        end
        for (int i = 0; i < plen; i++) begin
          vld = ($urandom_range(9) != 0);
          send_cmd(OP_PUSH, 8'($urandom_range(255)), vld, i == plen - 1,
                   8'($urandom_range(255)), 1'b0, ST_OK, 4'd0);
          sent++;
          // Now and then a pop, snoop or drop lands in the middle of an open packet.
          if (i < plen - 1 && $urandom_range(24) == 0) begin
            send_cmd(op_e'($urandom_range(1, 3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     8'($urandom_range(0, 17)), 1'b0, ST_OK, 4'd0);
            sent++;
          end
        end
      end else begin
        send_cmd(op_e'($urandom_range(1, 3)), 8'($urandom_range(255)),
                 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'(($urandom_range(9) < 7) ? $urandom_range(0, 17) : $urandom_range(0, 255)),
                 1'b0, ST_OK, 4'd0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    beat_t got, want;
    if (rst_ni && out_strobe_o) begin
      got.status = status_o;
      got.data   = out_byte_o;
      got.length = packet_length_o;
      got.depth  = queue_depth_o;
      got.eor    = end_of_run_o;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d byte %02h len %0d depth %0d end %0b",
                   got.status, got.data, got.length, got.depth, got.eor);
      end else begin
        want = pending_beats.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.length !== want.length || got.depth !== want.depth ||
            got.eor !== want.eor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d byte %02h len %0d depth %0d end %0b, %s",
                     want.status, want.data, want.length, want.depth, want.eor,
                     $sformatf("got status %0d byte %02h len %0d depth %0d end %0b",
                               got.status, got.data, got.length, got.depth, got.eor));
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    mismatches   = 0;
    burst        = 1'b0;
    slots_reg    = 4'((SLOTS < 8) ? SLOTS : 8);
    wr_slot      = 0;
    rd_slot      = 0;
    held_packets = 0;
    open_bytes   = 0;
    rejecting    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_slots(4'd1);
    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int i = 0; i < row.reps; i++)
        send_cmd(row.op, row.data + i[7:0], row.vld, row.lst && (i == row.reps - 1),
                 row.limit, row.typed, row.st, row.depth);
    end

    random_phase(4'd15, 35);
    random_phase(4'd0, 30);
    random_phase(4'd8, 40);
    random_phase(4'd3, 35);
    random_phase(4'd1, 30);
    random_phase(4'($urandom_range(2, 7)), 35);

    start_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* packet_ring_fifo.f */
rtl/core/prf_pkg.sv
rtl/core/prf_front.sv
rtl/core/prf_back.sv
rtl/core/packet_ring_fifo.sv
verif/tb_packet_ring_fifo.sv
